// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [PRIO_W-1:0]   t_prio;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [OCC_W-1:0]    t_occ;

    // controller to datapath
    typedef struct packed {
        logic    load;     // capture the incoming transaction
        logic    execute;  // write the result registers
        logic    do_ins;   // place the captured entry into the store
        logic    do_rem;   // pop the head of the store
        t_status status;   // status reported with the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mode;   // captured operation
        logic full;
        logic empty;
    } t_stat;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a sorted shift-register list; lowest
// priority value leaves first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// start is taken only while idle and loads the transaction; the execute state
//   then writes the result registers and the result strobe; busy covers the
//   single execute cycle in which all slots compare and shift in parallel
// a new transaction may be started in the cycle its predecessor's result shows
// reset (synchronous, active low) empties the queue; stored entries are kept
//   only as far as the count says
module sorted_priority_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  spq_pkg::t_id         i_in_id,
    input  spq_pkg::t_prio       i_in_priority,
    output logic                 o_valid,
    output spq_pkg::t_id         o_out_id,
    output spq_pkg::t_prio       o_out_priority,
    output spq_pkg::t_status     o_status,
    output spq_pkg::t_occ        o_occupancy
);
    import spq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // store and results
    spq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_mode         (i_mode),
        .i_in_id        (i_in_id),
        .i_in_priority  (i_in_priority),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

endmodule

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller for the sorted priority queue: takes a transaction, decides the
// operation from the queue status and strobes the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    input  spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd  o_cmd
);
    import spq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_valid;
    logic n_valid;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        o_cmd.status = ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
                if (i_stat.mode == MODE_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.do_ins = 1'b1;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.do_rem = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== hdl/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Datapath for the sorted priority queue: a sorted shift-register store with
// one comparator per slot, the entry count and the result registers.
// ----------------------------------------------------------------------------
module spq_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spq_pkg::t_cmd        i_cmd,
    output spq_pkg::t_stat       o_stat,
    input  logic                 i_mode,
    input  spq_pkg::t_id         i_in_id,
    input  spq_pkg::t_prio       i_in_priority,
    output spq_pkg::t_id         o_out_id,
    output spq_pkg::t_prio       o_out_priority,
    output spq_pkg::t_status     o_status,
    output spq_pkg::t_occ        o_occupancy
);
    import spq_pkg::*;

    // captured transaction
    logic  r_mode;
    t_id   r_id;
    t_prio r_prio;

    // sorted store, head at slot zero
    t_id    r_st_id   [QUEUE_DEPTH];
    t_prio  r_st_prio [QUEUE_DEPTH];
    t_count r_count;
    t_count n_count;

    // result registers
    t_id     r_out_id;
    t_prio   r_out_prio;
    t_status r_status;
    t_occ    r_occ;

    logic [QUEUE_DEPTH-1:0] w_gt;

    // slots holding an entry that must move behind the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) && (r_st_prio[i] > r_prio);
        end
    end

    assign o_stat.mode  = r_mode;
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // count after the operation
    always_comb begin
        n_count = r_count;
        if (i_cmd.do_ins) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.do_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= i_in_id;
            r_prio <= i_in_priority;
        end
    end

    // store update: insert shifts the larger tail up, remove shifts down
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.do_ins) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    r_st_id[i]   <= r_st_id[(i > 0) ? i - 1 : 0];
                    r_st_prio[i] <= r_st_prio[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || CNT_W'(i) == r_count) begin
                    r_st_id[i]   <= r_id;
                    r_st_prio[i] <= r_prio;
                end
            end else if (i_cmd.do_rem && i < QUEUE_DEPTH - 1) begin
                r_st_id[i]   <= r_st_id[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_st_prio[i] <= r_st_prio[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_id   <= i_cmd.do_rem ? r_st_id[0] : '0;
            r_out_prio <= i_cmd.do_rem ? r_st_prio[0] : '0;
            r_status   <= i_cmd.status;
            r_occ      <= OCC_W'(n_count);
        end
    end

    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

endmodule
